// ===== rtl/core/bsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsrc_pkg
// Shared types, codes and defaults of the bandlimited sample rate converter.
// ----------------------------------------------------------------------------
package bsrc_pkg;

    localparam int TABLE_DEPTH_DEF   = 8192;
    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int MAX_OUT           = 64;

    // item modes
    localparam logic [1:0] MODE_COEF = 2'd0;
    localparam logic [1:0] MODE_DIFF = 2'd1;
    localparam logic [1:0] MODE_PUSH = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [2:0] CFG_FILTER_STEP = 3'd1;
    localparam logic [2:0] CFG_INTERP      = 3'd2;
    localparam logic [2:0] CFG_WING_LENGTH = 3'd3;
    localparam logic [2:0] CFG_GAIN        = 3'd4;
    localparam logic [2:0] CFG_REACH       = 3'd5;

    localparam logic [19:0] TIME_STEP_RST   = 20'd32768;
    localparam logic [15:0] FILTER_STEP_RST = 16'd32768;
    localparam logic [13:0] WING_LENGTH_RST = 14'd1536;
    localparam logic [15:0] GAIN_RST        = 16'd16384;
    localparam logic [9:0]  REACH_RST       = 10'd17;
    localparam logic [15:0] FILTER_STEP_MIN = 16'd2048;

    typedef struct packed {
        logic [1:0]         mode;
        logic [12:0]        table_index;
        logic signed [15:0] value;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               last_of_run;
    } out_t;

    // control from the tap sequencer to the MAC
    typedef struct packed {
        logic       clear;
        logic       issue;
        logic [6:0] frac;
        logic       interp;
    } mac_ctl_t;

endpackage

// ===== rtl/core/bsrc_ram.sv =====
// ----------------------------------------------------------------------------
// bsrc_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/bsrc_mac.sv =====
// ----------------------------------------------------------------------------
// bsrc_mac
// Tap pipeline: coefficient interpolation, product rounding, accumulation.
// ----------------------------------------------------------------------------
module bsrc_mac
    import bsrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mac_ctl_t           ctl,
    input  logic [15:0]        coef_q,
    input  logic [15:0]        diff_q,
    input  logic [15:0]        hist_q,
    output logic signed [31:0] acc,
    output logic               busy
);

    logic               v1_reg, v2_reg, v3_reg;
    logic [6:0]         frac1_reg;
    logic signed [15:0] coef_reg, x_reg;
    logic signed [23:0] dp_reg;
    logic signed [32:0] prod_reg;
    logic signed [31:0] acc_reg;
    logic signed [16:0] c_sum;
    logic signed [32:0] prod_w;
    logic signed [18:0] rnd;

    assign c_sum  = 17'($signed(coef_reg)) + (ctl.interp ? 17'(dp_reg >>> 7) : 17'sd0);
    assign prod_w = 33'(c_sum) * 33'(x_reg);
    assign rnd    = 19'((prod_reg + 33'sd8192) >>> 14);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
            else if (v3_reg)
            begin
                acc_reg <= acc_reg + 32'(rnd);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        frac1_reg <= ctl.frac;
        coef_reg  <= $signed(coef_q);
        x_reg     <= $signed(hist_q);
        dp_reg    <= 24'($signed(diff_q)) * 24'($signed({1'b0, frac1_reg}));
        prod_reg  <= prod_w;
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg | v3_reg;

endmodule

// ===== rtl/core/bandlimited_sample_rate_converter.sv =====
// ----------------------------------------------------------------------------
// bandlimited_sample_rate_converter
// Windowed-sinc resampler: tables and history in RAM, one shared MAC.
// ----------------------------------------------------------------------------
// Sequence: a push with no output due passes the gap check and returns to idle;
//   each output walks both wings, one tap per cycle through the MAC.
// Throughput: one table load per cycle while idle; outputs are bounded by the tap loop.
// Reset: registers clear at once, then every history RAM entry is zeroed;
//   while that sweep runs no request is taken (config is).
// ----------------------------------------------------------------------------
module bandlimited_sample_rate_converter
    import bsrc_pkg::*;
#(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  in_t         item,
    output logic        result_valid,
    input  logic        result_ready,
    output out_t        result
);

    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int HAW = $clog2(HISTORY_DEPTH);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_GAP   = 4'd2;
    localparam logic [3:0] ST_INIT  = 4'd3;
    localparam logic [3:0] ST_SETUP = 4'd4;
    localparam logic [3:0] ST_TAP   = 4'd5;
    localparam logic [3:0] ST_DRAIN = 4'd6;
    localparam logic [3:0] ST_SCALE = 4'd7;
    localparam logic [3:0] ST_ROUND = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    // configuration
    logic [19:0] time_step_reg;
    logic [15:0] filter_step_reg;
    logic        interp_reg;
    logic [13:0] wing_length_reg;
    logic [15:0] gain_reg;
    logic [9:0]  reach_reg;

    // sequencer state
    logic [3:0]         state_reg, state_next;
    logic [HAW-1:0]     clr_addr_reg;
    logic [31:0]        tpos_reg;
    logic [16:0]        rc_reg;
    logic [6:0]         cnt_reg;
    logic               side_reg;
    logic [21:0]        ho_reg;
    logic [HAW-1:0]     sidx_reg;
    logic signed [46:0] mul_reg;
    logic signed [15:0] res_reg;
    logic               result_valid_reg;
    out_t               result_reg;

    logic        accept, clearing, ready_now, in_range, load_out, last_now;
    logic [15:0] step;
    logic [14:0] ph;
    logic [16:0] gap;
    logic [16:0] xi;
    logic [15:0] tap_pos;
    logic [30:0] ph_prod;
    logic signed [31:0] acc;
    logic        mac_busy;
    mac_ctl_t    mac_ctl;
    logic signed [46:0] mul_w, rv;
    logic [15:0] coef_q, diff_q, hist_q;
    logic        hist_we;
    logic [HAW-1:0] hist_waddr;
    logic [15:0] hist_wdata;

    assign clearing   = (state_reg == ST_CLEAR);
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    assign step = (filter_step_reg < FILTER_STEP_MIN) ? FILTER_STEP_MIN : filter_step_reg;
    assign xi   = tpos_reg[31:15];

    // an output is due once sample floor(time)+reach is in the ring
    assign gap       = rc_reg - 17'd1 - xi - 17'(reach_reg);
    assign ready_now = !gap[16];
    assign last_now  = !ready_now || (cnt_reg == 7'(MAX_OUT));

    // left wing uses the time fraction, right wing its complement
    assign ph      = side_reg ? 15'(17'd0 - {2'b00, tpos_reg[14:0]}) : tpos_reg[14:0];
    assign ph_prod = 31'(ph) * 31'(step);

    // right wing stops one entry earlier
    assign tap_pos  = {1'b0, ho_reg[21:7]} + {15'd0, side_reg};
    assign in_range = tap_pos < {2'b00, wing_length_reg};

    assign mac_ctl.clear  = (state_reg == ST_INIT);
    assign mac_ctl.issue  = (state_reg == ST_TAP) && in_range;
    assign mac_ctl.frac   = ho_reg[6:0];
    assign mac_ctl.interp = interp_reg;

    assign mul_w = 47'(acc >>> 2) * 47'($signed({1'b0, gain_reg}));
    assign rv    = (mul_reg + 47'sd4096) >>> 13;

    assign load_out = (state_reg == ST_EMIT) && (!result_valid_reg || result_ready);

    // history write: clearing sweep or pushed sample
    assign hist_we    = clearing || (accept && item.mode == MODE_PUSH);
    assign hist_waddr = clearing ? clr_addr_reg : rc_reg[HAW-1:0];
    assign hist_wdata = clearing ? 16'd0 : item.value;

    bsrc_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_coef (
        .clk   (clk),
        .we    (accept && item.mode == MODE_COEF),
        .waddr (TAW'(item.table_index)),
        .wdata (item.value),
        .raddr (ho_reg[7 +: TAW]),
        .rdata (coef_q)
    );

    bsrc_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_diff (
        .clk   (clk),
        .we    (accept && item.mode == MODE_DIFF),
        .waddr (TAW'(item.table_index)),
        .wdata (item.value),
        .raddr (ho_reg[7 +: TAW]),
        .rdata (diff_q)
    );

    bsrc_ram #(.WIDTH(16), .DEPTH(HISTORY_DEPTH)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (sidx_reg),
        .rdata (hist_q)
    );

    bsrc_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .coef_q (coef_q),
        .diff_q (diff_q),
        .hist_q (hist_q),
        .acc    (acc),
        .busy   (mac_busy)
    );

    // configuration writes are taken in any state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg   <= TIME_STEP_RST;
            filter_step_reg <= FILTER_STEP_RST;
            interp_reg      <= 1'b0;
            wing_length_reg <= WING_LENGTH_RST;
            gain_reg        <= GAIN_RST;
            reach_reg       <= REACH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIME_STEP:   time_step_reg   <= cfg_data;
                CFG_FILTER_STEP: filter_step_reg <= cfg_data[15:0];
                CFG_INTERP:      interp_reg      <= cfg_data[0];
                CFG_WING_LENGTH: wing_length_reg <= cfg_data[13:0];
                CFG_GAIN:        gain_reg        <= cfg_data[15:0];
                CFG_REACH:       reach_reg       <= cfg_data[9:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == HAW'(HISTORY_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && item.mode == MODE_PUSH)
                begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP:   state_next = ready_now ? ST_INIT : ST_IDLE;
            ST_INIT:  state_next = ST_SETUP;
            ST_SETUP: state_next = ST_TAP;
            ST_TAP:
            begin
                if (!in_range)
                begin
                    state_next = side_reg ? ST_DRAIN : ST_SETUP;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_ROUND;
            ST_ROUND: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = last_now ? ST_IDLE : ST_INIT;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            tpos_reg         <= '0;
            rc_reg           <= '0;
            cnt_reg          <= '0;
            side_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + HAW'(1);
            end
            if (accept && item.mode == MODE_PUSH)
            begin
                rc_reg <= rc_reg + 17'd1;
            end
            case (state_reg)
                ST_GAP:   cnt_reg  <= '0;
                ST_INIT:  side_reg <= 1'b0;
                ST_TAP:
                begin
                    if (!in_range)
                    begin
                        side_reg <= 1'b1;
                    end
                end
                ST_ROUND:
                begin
                    // advance output time and count for this push
                    tpos_reg <= tpos_reg + 32'(time_step_reg);
                    cnt_reg  <= cnt_reg + 7'd1;
                end
                default:  ;
            endcase
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // tap walk and result datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_SETUP:
            begin
                // at phase zero the right wing starts one step in
                ho_reg   <= 22'(ph_prod >> 15)
                            + ((side_reg && ph == 15'd0) ? 22'(step) : 22'd0);
                sidx_reg <= side_reg ? xi[HAW-1:0] + HAW'(1) : xi[HAW-1:0];
            end
            ST_TAP:
            begin
                if (in_range)
                begin
                    ho_reg   <= ho_reg + 22'(step);
                    sidx_reg <= side_reg ? sidx_reg + HAW'(1) : sidx_reg - HAW'(1);
                end
            end
            ST_SCALE: mul_reg <= mul_w;
            ST_ROUND:
            begin
                if (rv > 47'sd32767)
                begin
                    res_reg <= 16'sh7fff;
                end
                else if (rv < -47'sd32768)
                begin
                    res_reg <= -16'sh8000;
                end
                else
                begin
                    res_reg <= 16'(rv);
                end
            end
            default:  ;
        endcase
        if (load_out)
        begin
            result_reg.out_sample  <= res_reg;
            result_reg.last_of_run <= last_now;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the MAC must be empty when the sum is scaled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |-> !mac_busy)
        else $error("scale started with taps in flight");

    // never more outputs per push than the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'(MAX_OUT))
        else $error("output count past cap");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && result_valid_reg) |-> result_ready)
        else $error("result overwritten");

    // no request taken during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !item_ready)
        else $error("request taken while clearing");

endmodule
